### hw/rtl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants for the connection request serializer.
// Holds the word structs, event and action codes, and controller types.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int QueueDepth    = 16;
  localparam int IncomingDepth = 8;
  localparam int QIdxW   = $clog2(QueueDepth);
  localparam int QCntW   = $clog2(QueueDepth + 1);
  localparam int SIdxW   = (IncomingDepth > 1) ? $clog2(IncomingDepth) : 1;
  localparam int AddrW   = 48;

  typedef enum logic [2:0] {
    KIND_ENQ_CONNECT    = 3'd0,
    KIND_ENQ_NAME       = 3'd1,
    KIND_REG_INCOMING   = 3'd2,
    KIND_CONNECT_DONE   = 3'd3,
    KIND_CANCEL_CONNECT = 3'd4,
    KIND_NAME_DONE      = 3'd5,
    KIND_CANCEL_NAME    = 3'd6,
    KIND_STOP           = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    ACT_START_CONN       = 4'd0,
    ACT_START_NAME       = 4'd1,
    ACT_OUT_DONE         = 4'd2,
    ACT_IN_DONE          = 4'd3,
    ACT_UNKNOWN          = 4'd4,
    ACT_CANCEL_OUT_CONN  = 4'd5,
    ACT_CANCEL_OUT_NAME  = 4'd6,
    ACT_Q_CONN_CANCELLED = 4'd7,
    ACT_Q_NAME_CANCELLED = 4'd8,
    ACT_NOT_FOUND        = 4'd9,
    ACT_QUEUE_FULL       = 4'd10,
    ACT_SET_FULL         = 4'd11
  } action_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [AddrW-1:0] address;
  } in_word_t;

  typedef struct packed {
    logic [3:0]       action;
    logic [AddrW-1:0] result_address;
    logic             last;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SET_SCAN,
    ST_SET_FIN,
    ST_Q_READ,
    ST_Q_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_START,
    ST_HEAD_WAIT,
    ST_HEAD_TAKE
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic       latch_in;     // capture input word
    logic       set_scan;     // examine one incoming slot
    logic       set_clr_idx;  // reset scan index
    logic       q_rd;         // read queue at index
    logic       q_idx_clr;    // index := 0
    logic       q_idx_inc;    // index += 1
    logic       q_shift_wr;   // write read data to index-1
    logic       q_push;       // write latched request at count
    logic       cnt_dec;
    logic       out_clear;    // clear outgoing valid
    logic       out_load;     // load outgoing from queue read data
    logic       set_remove;   // clear matching incoming slot
    logic       set_add;      // write free slot
    logic       stop_set;
    logic       emit;
    logic [3:0] emit_act;
    logic       emit_head;    // result address from queue head
    logic       emit_last;
  } crs_cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic [2:0] kind;
    logic       q_full;
    logic       q_empty;
    logic       can_start;    // running, idle slot, empty set
    logic       run_ready;    // running, empty set
    logic       out_conn_hit; // outgoing connect with input address
    logic       out_cancel_hit;
    logic       q_match;      // registered queue entry matches
    logic       q_idx_end;    // index + 1 >= count
    logic       q_idx_past;   // index >= count
    logic       set_done;     // last incoming slot examined
    logic       set_hit;      // input address found in set
    logic       set_free;     // free slot seen
    logic       head_name;
  } crs_sts_t;

endpackage

### hw/rtl/connection_request_serializer_unit.sv
// ----------------------------------------------------------------------------
// connection_request_serializer_unit: top level of the request serializer.
// Joins the sequencing controller and the queue and set datapath.
// ----------------------------------------------------------------------------
// Usage. An event word (in_word: kind and address) is taken on a rising edge
// with start high and busy low. Results leave on out_word, one per cycle at
// most, each marked by out_valid for exactly one cycle; the receiver cannot
// stall, so every strobed word must be captured when it appears. The final
// result of an event carries last set; an event may give none, one or two.
// A result reaches the ports in the cycle after the controller step that
// makes it, so the last one may still be there in the first cycle after busy
// falls. Stop and outgoing cancels finish in the dispatch step; an incoming
// registration or an unmatched completion scans every incoming slot in turn;
// a start and a queued cancel search and compact the queue memory, which has
// one write and one registered read port, reading each entry before it is
// compared or moved.
// Reset (synchronous, rst_n low) empties the queue and the incoming set, clears
// the outgoing slot and the stop flag; queue contents are left undefined.
// ----------------------------------------------------------------------------
module connection_request_serializer_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  crs_pkg::in_word_t   in_word,
  output logic                out_valid,
  output crs_pkg::out_word_t  out_word
);
  import crs_pkg::*;

  crs_cmd_t cmd;
  crs_sts_t sts;

  // The controller sequences each event; the datapath holds the queue, slot and set state.
  crs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  crs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef NO_ASSERTIONS
  // An accepted word always makes the controller busy in the cycle after.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");
  // A result that is not the last one means the event is still in progress.
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last) |-> busy)
    else $error("non-final result with the block idle");
  a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.action <= ACT_SET_FULL))
    else $error("bad action");
`endif

endmodule

### hw/rtl/crs_datapath.sv
// ----------------------------------------------------------------------------
// crs_datapath: request queue memory, outgoing slot and incoming set.
// Executes one controller command word per cycle.
// ----------------------------------------------------------------------------
module crs_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  crs_pkg::in_word_t   in_word,
  input  crs_pkg::crs_cmd_t   cmd,
  output crs_pkg::crs_sts_t   sts,
  output logic                out_valid,
  output crs_pkg::out_word_t  out_word
);
  import crs_pkg::*;

  logic [AddrW:0]   qmem [QueueDepth];
  logic [AddrW:0]   qrd_r;
  logic [QCntW-1:0] cnt_r;
  logic [QCntW-1:0] idx_r;
  logic [2:0]       kind_r;
  logic [AddrW-1:0] addr_r;
  logic             ov_r, oname_r;
  logic [AddrW-1:0] oaddr_r;
  logic             stop_r;
  logic             sv_r [IncomingDepth];
  logic [AddrW-1:0] sa_r [IncomingDepth];
  logic [SIdxW-1:0] sidx_r;
  logic [SIdxW-1:0] hit_idx_r, free_idx_r;
  logic             hit_r, free_r;
  logic             ovalid_r;
  out_word_t        oword_r;
  logic             any_valid;
  logic             is_name;

  assign is_name = (kind_r == KIND_CANCEL_NAME);

  always_comb begin
    any_valid = 1'b0;
    for (int i = 0; i < IncomingDepth; i++) any_valid = any_valid | sv_r[i];
  end

  // Queue memory: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.q_push) begin
      qmem[cnt_r[QIdxW-1:0]] <= {(kind_r == KIND_ENQ_NAME), addr_r};
    end else if (cmd.q_shift_wr) begin
      qmem[QIdxW'(idx_r - 1'b1)] <= qrd_r;
    end
    if (cmd.q_rd) begin
      qrd_r <= qmem[idx_r[QIdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      kind_r <= in_word.kind;
      addr_r <= in_word.address;
    end
    if (cmd.out_load) oaddr_r <= qrd_r[AddrW-1:0];
    if (cmd.set_add) sa_r[free_idx_r] <= addr_r;
    if (cmd.set_scan) begin
      if (sv_r[sidx_r] && sa_r[sidx_r] == addr_r && !hit_r) hit_idx_r <= sidx_r;
      if (!sv_r[sidx_r] && !free_r) free_idx_r <= sidx_r;
    end
    if (cmd.emit) begin
      oword_r.action         <= cmd.emit_act;
      oword_r.result_address <= cmd.emit_head ? qrd_r[AddrW-1:0] : addr_r;
      oword_r.last           <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      idx_r    <= '0;
      ov_r     <= 1'b0;
      oname_r  <= 1'b0;
      stop_r   <= 1'b0;
      sidx_r   <= '0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < IncomingDepth; i++) sv_r[i] <= 1'b0;
    end else begin
      ovalid_r <= cmd.emit;
      if (cmd.q_push) cnt_r <= cnt_r + 1'b1;
      else if (cmd.cnt_dec) cnt_r <= cnt_r - 1'b1;
      if (cmd.q_idx_clr) idx_r <= '0;
      else if (cmd.q_idx_inc) idx_r <= idx_r + 1'b1;
      if (cmd.out_clear) ov_r <= 1'b0;
      else if (cmd.out_load) begin
        ov_r    <= 1'b1;
        oname_r <= qrd_r[AddrW];
      end
      if (cmd.stop_set) stop_r <= 1'b1;
      if (cmd.set_clr_idx) begin
        sidx_r <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
      end else if (cmd.set_scan) begin
        if (sv_r[sidx_r] && sa_r[sidx_r] == addr_r) hit_r <= 1'b1;
        if (!sv_r[sidx_r]) free_r <= 1'b1;
        sidx_r <= SIdxW'(sidx_r + 1'b1);
      end
      if (cmd.set_remove) sv_r[hit_idx_r] <= 1'b0;
      if (cmd.set_add) sv_r[free_idx_r] <= 1'b1;
    end
  end

  always_comb begin
    sts.kind           = kind_r;
    sts.q_full         = (cnt_r == QCntW'(QueueDepth));
    sts.q_empty        = (cnt_r == '0);
    sts.can_start      = !stop_r && !ov_r && !any_valid;
    sts.run_ready      = !stop_r && !any_valid;
    sts.out_conn_hit   = ov_r && !oname_r && (oaddr_r == addr_r);
    sts.out_cancel_hit = ov_r && (oname_r == is_name) && (oaddr_r == addr_r);
    sts.q_match        = (qrd_r[AddrW] == is_name) && (qrd_r[AddrW-1:0] == addr_r);
    sts.q_idx_end      = ({1'b0, idx_r} + 1'b1) >= {1'b0, cnt_r};
    sts.q_idx_past     = idx_r >= cnt_r;
    sts.set_done       = (sidx_r == SIdxW'(IncomingDepth - 1));
    sts.set_hit        = hit_r;
    sts.set_free       = free_r;
    sts.head_name      = qrd_r[AddrW];
  end

  assign out_valid = ovalid_r;
  assign out_word  = oword_r;

endmodule

### hw/rtl/crs_ctrl.sv
// ----------------------------------------------------------------------------
// crs_ctrl: sequencing state machine for the request serializer.
// Walks the incoming set one slot per cycle and the queue entry by entry.
// ----------------------------------------------------------------------------
module crs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  crs_pkg::crs_sts_t  sts,
  output crs_pkg::crs_cmd_t  cmd
);
  import crs_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (kind_t'(sts.kind))
          KIND_ENQ_CONNECT, KIND_ENQ_NAME: state_nxt = ST_START;
          KIND_REG_INCOMING: state_nxt = ST_SET_SCAN;
          KIND_CONNECT_DONE: begin
            if (sts.out_conn_hit) state_nxt = ST_START;
            else state_nxt = ST_SET_SCAN;
          end
          KIND_CANCEL_CONNECT, KIND_CANCEL_NAME: begin
            if (sts.out_cancel_hit || sts.q_empty) state_nxt = ST_IDLE;
            else state_nxt = ST_Q_READ;
          end
          KIND_NAME_DONE: state_nxt = ST_START;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_SET_SCAN: if (sts.set_done) state_nxt = ST_SET_FIN;
      ST_SET_FIN: state_nxt = ST_IDLE;
      ST_Q_READ: state_nxt = ST_Q_CMP;
      ST_Q_CMP: begin
        if (sts.q_match) begin
          state_nxt = sts.q_idx_end ? ST_IDLE : ST_SHIFT_RD;
        end else if (sts.q_idx_end) state_nxt = ST_IDLE;
        else state_nxt = ST_Q_READ;
      end
      ST_SHIFT_RD: state_nxt = ST_SHIFT_WR;
      // The count has already dropped by one here, so the walk ends once the
      // source index reaches it.
      ST_SHIFT_WR: state_nxt = sts.q_idx_past ? ST_IDLE : ST_SHIFT_RD;
      ST_START: begin
        if (sts.can_start && !sts.q_empty) state_nxt = ST_HEAD_WAIT;
        else state_nxt = ST_IDLE;
      end
      ST_HEAD_WAIT: state_nxt = ST_HEAD_TAKE;
      ST_HEAD_TAKE: state_nxt = sts.q_idx_end ? ST_IDLE : ST_SHIFT_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: cmd.latch_in = start;
      ST_DISPATCH: begin
        cmd.q_idx_clr   = 1'b1;
        cmd.set_clr_idx = 1'b1;
        case (kind_t'(sts.kind))
          KIND_ENQ_CONNECT, KIND_ENQ_NAME: begin
            if (sts.q_full) begin
              cmd.emit     = 1'b1;
              cmd.emit_act = ACT_QUEUE_FULL;
              cmd.emit_last = !(sts.can_start);
            end else cmd.q_push = 1'b1;
          end
          KIND_CONNECT_DONE: begin
            if (sts.out_conn_hit) begin
              cmd.out_clear = 1'b1;
              cmd.emit      = 1'b1;
              cmd.emit_act  = ACT_OUT_DONE;
              // The slot is being freed, so a start follows when the block
              // runs, the set is empty and the queue holds a request.
              cmd.emit_last = !(sts.run_ready && !sts.q_empty);
            end
          end
          KIND_CANCEL_CONNECT, KIND_CANCEL_NAME: begin
            if (sts.out_cancel_hit) begin
              cmd.emit      = 1'b1;
              cmd.emit_act  = (kind_t'(sts.kind) == KIND_CANCEL_NAME) ?
                              ACT_CANCEL_OUT_NAME : ACT_CANCEL_OUT_CONN;
              cmd.emit_last = 1'b1;
            end else if (sts.q_empty) begin
              cmd.emit      = 1'b1;
              cmd.emit_act  = ACT_NOT_FOUND;
              cmd.emit_last = 1'b1;
            end
          end
          KIND_NAME_DONE: cmd.out_clear = 1'b1;
          KIND_STOP: cmd.stop_set = 1'b1;
          default: ;
        endcase
      end
      ST_SET_SCAN: cmd.set_scan = 1'b1;
      // Hit and free flags now cover every slot.
      ST_SET_FIN: begin
        if (kind_t'(sts.kind) == KIND_REG_INCOMING) begin
          if (!sts.set_hit) begin
            if (sts.set_free) cmd.set_add = 1'b1;
            else begin
              cmd.emit      = 1'b1;
              cmd.emit_act  = ACT_SET_FULL;
              cmd.emit_last = 1'b1;
            end
          end
        end else begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          if (sts.set_hit) begin
            cmd.set_remove = 1'b1;
            cmd.emit_act   = ACT_IN_DONE;
          end else cmd.emit_act = ACT_UNKNOWN;
        end
      end
      ST_Q_READ: cmd.q_rd = 1'b1;
      ST_Q_CMP: begin
        cmd.q_idx_inc = 1'b1;
        if (sts.q_match) begin
          cmd.cnt_dec   = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_act  = (kind_t'(sts.kind) == KIND_CANCEL_NAME) ?
                          ACT_Q_NAME_CANCELLED : ACT_Q_CONN_CANCELLED;
          cmd.emit_last = 1'b1;
        end else if (sts.q_idx_end) begin
          cmd.emit      = 1'b1;
          cmd.emit_act  = ACT_NOT_FOUND;
          cmd.emit_last = 1'b1;
        end
      end
      ST_SHIFT_RD: cmd.q_rd = 1'b1;
      ST_SHIFT_WR: begin
        cmd.q_shift_wr = 1'b1;
        cmd.q_idx_inc  = 1'b1;
      end
      ST_START: cmd.q_rd = 1'b1;
      ST_HEAD_TAKE: begin
        cmd.out_load  = 1'b1;
        cmd.cnt_dec   = 1'b1;
        cmd.q_idx_inc = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_head = 1'b1;
        cmd.emit_act  = sts.head_name ? ACT_START_NAME : ACT_START_CONN;
        cmd.emit_last = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
